// ===== hdl/ccf_pkg.sv =====
`default_nettype none

package ccf_pkg;

  localparam int unsigned SCR_BITS   = 11;
  localparam int unsigned POS_BITS   = 12;
  localparam int unsigned CRD_BITS   = 13;
  localparam int unsigned PIX_BITS   = 10;
  localparam int unsigned RAD_BITS   = 10;
  localparam int unsigned DLT_BITS   = 11;
  localparam int unsigned SQ_BITS    = 20;
  localparam int unsigned ADDR_BITS  = 20;
  localparam int unsigned COLOR_BITS = 32;
  localparam int unsigned PORT_COLOR_BITS = 32;

  localparam logic [SCR_BITS-1:0] MAX_SCREEN_WIDTH  = 11'd1024;
  localparam logic [SCR_BITS-1:0] MAX_SCREEN_HEIGHT = 11'd1024;
  localparam logic [SCR_BITS-1:0] RESET_WIDTH       = 11'd640;
  localparam logic [SCR_BITS-1:0] RESET_HEIGHT      = 11'd480;

  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_BITS = $clog2(Q_DEPTH);

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_STEP      = 1'b1;
  localparam logic SHAPE_RECT   = 1'b0;
  localparam logic SHAPE_CIRCLE = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // one raster iteration, classified by the front part
  typedef struct packed {
    logic                        active;
    logic                        kind;
    logic                        main_on;
    logic                        mirror_on;
    logic [PIX_BITS-1:0]         sx;
    logic [PIX_BITS-1:0]         sy;
    logic [PIX_BITS-1:0]         mx;
    logic signed [DLT_BITS-1:0]  dx;
    logic signed [DLT_BITS-1:0]  dy;
    logic [RAD_BITS-1:0]         radius;
    logic [COLOR_BITS-1:0]       color;
    logic                        done;
  } job_t;

  function automatic logic on_axis(logic signed [CRD_BITS-1:0] c,
                                   logic [SCR_BITS-1:0] lim);
    return !c[CRD_BITS-1] && (c[POS_BITS-1:0] < {1'b0, lim});
  endfunction

  function automatic logic [SCR_BITS-1:0] sat_dim(logic [SCR_BITS-1:0] v,
                                                  logic [SCR_BITS-1:0] maxv);
    return (v > maxv) ? maxv : v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ccf_front.sv =====
`default_nettype none

module ccf_front import ccf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 operation,
  input  wire logic                 shape_kind,
  input  wire logic [POS_BITS-1:0]  pos_x,
  input  wire logic [POS_BITS-1:0]  pos_y,
  input  wire logic [SCR_BITS-1:0]  extent_w,
  input  wire logic [SCR_BITS-1:0]  extent_h,
  input  wire logic [RAD_BITS-1:0]  circle_radius,
  input  wire logic [COLOR_BITS-1:0] fill_color,
  input  wire logic [SCR_BITS-1:0]  eff_w,
  input  wire logic [SCR_BITS-1:0]  eff_h,
  output logic                      push,
  output job_t                      job
);

  logic                  kind_r;
  logic [POS_BITS-1:0]   origin_x_r;
  logic [POS_BITS-1:0]   origin_y_r;
  logic [SCR_BITS-1:0]   row_limit_r;
  logic [SCR_BITS-1:0]   col_limit_r;
  logic [RAD_BITS-1:0]   radius_r;
  logic [COLOR_BITS-1:0] color_r;
  logic [SCR_BITS-1:0]   row_index_r;
  logic [SCR_BITS-1:0]   col_index_r;
  logic                  busy_r;

  logic signed [CRD_BITS-1:0] ox, oy, roff, sx, sy, mx;
  logic [SCR_BITS:0]          col_inc, row_inc;
  logic                       col_wrap, row_wrap;
  logic [SCR_BITS-1:0]        row_limit_nxt, col_limit_nxt;

  assign ox   = {origin_x_r[POS_BITS-1], origin_x_r};
  assign oy   = {origin_y_r[POS_BITS-1], origin_y_r};
  assign roff = (kind_r == SHAPE_CIRCLE) ? {3'b000, radius_r} : '0;
  assign sx   = ox + {2'b00, col_index_r} - roff;
  assign sy   = oy + {2'b00, row_index_r} - roff;
  assign mx   = ox + {3'b000, radius_r} - {2'b00, col_index_r};

  assign col_inc  = {1'b0, col_index_r} + 1'b1;
  assign row_inc  = {1'b0, row_index_r} + 1'b1;
  assign col_wrap = col_inc >= {1'b0, col_limit_r};
  assign row_wrap = row_inc >= {1'b0, row_limit_r};

  assign row_limit_nxt = (shape_kind == SHAPE_CIRCLE) ? {circle_radius, 1'b0} : extent_h;
  assign col_limit_nxt = (shape_kind == SHAPE_CIRCLE) ? {1'b0, circle_radius} : extent_w;

  assign push = accept && (operation == OP_STEP);

  always_comb begin
    job.active    = busy_r;
    job.kind      = kind_r;
    job.main_on   = on_axis(sx, eff_w) && on_axis(sy, eff_h);
    job.mirror_on = on_axis(mx, eff_w);
    job.sx        = sx[PIX_BITS-1:0];
    job.sy        = sy[PIX_BITS-1:0];
    job.mx        = mx[PIX_BITS-1:0];
    job.dx        = DLT_BITS'({1'b0, col_index_r} - {2'b00, radius_r});
    job.dy        = DLT_BITS'({1'b0, row_index_r} - {2'b00, radius_r});
    job.radius    = radius_r;
    job.color     = color_r;
    job.done      = !busy_r || (col_wrap && row_wrap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= SHAPE_RECT;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      row_limit_r <= '0;
      col_limit_r <= '0;
      radius_r    <= '0;
      color_r     <= '0;
      row_index_r <= '0;
      col_index_r <= '0;
      busy_r      <= 1'b0;
    end else if (accept) begin
      if (operation == OP_LOAD) begin
        kind_r      <= shape_kind;
        origin_x_r  <= pos_x;
        origin_y_r  <= pos_y;
        radius_r    <= circle_radius;
        color_r     <= fill_color;
        row_limit_r <= row_limit_nxt;
        col_limit_r <= col_limit_nxt;
        row_index_r <= '0;
        col_index_r <= '0;
        busy_r      <= (row_limit_nxt != '0) && (col_limit_nxt != '0);
      end else if (busy_r) begin
        if (col_wrap) begin
          col_index_r <= '0;
          if (row_wrap) begin
            row_index_r <= '0;
            busy_r      <= 1'b0;
          end else begin
            row_index_r <= row_inc[SCR_BITS-1:0];
          end
        end else begin
          col_index_r <= col_inc[SCR_BITS-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccf_queue.sv =====
`default_nettype none

module ccf_queue import ccf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output job_t      pop_data
);

  job_t                  slot_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_BITS:0]   count_r;
  logic                  do_push, do_pop;

  assign full      = count_r == (Q_PTR_BITS+1)'(Q_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccf_back.sv =====
`default_nettype none

module ccf_back import ccf_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     job_valid,
  input  job_t                          job,
  output logic                          job_pop,
  input  wire logic [SCR_BITS-1:0]      eff_w,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_main_valid,
  output logic [ADDR_BITS-1:0]          out_main_address,
  output logic                          out_mirror_valid,
  output logic [ADDR_BITS-1:0]          out_mirror_address,
  output logic [PORT_COLOR_BITS-1:0]    out_pixel_color,
  output logic                          out_walk_done
);

  typedef struct packed {
    logic                  active;
    logic                  kind;
    logic                  main_on;
    logic                  mirror_on;
    logic [PIX_BITS-1:0]   sx;
    logic [PIX_BITS-1:0]   mx;
    logic [ADDR_BITS-1:0]  row_base;
    logic [SQ_BITS-1:0]    dx2;
    logic [SQ_BITS-1:0]    dy2;
    logic [SQ_BITS-1:0]    rsq;
    logic [COLOR_BITS-1:0] color;
    logic                  done;
  } prod_t;

  logic  s1_v_r;
  prod_t s1_r, s1_nxt;
  logic  out_adv, s1_ready;

  logic signed [2*DLT_BITS-1:0] dx2_full, dy2_full;
  logic [2*RAD_BITS-1:0]        rsq_full;
  logic [PIX_BITS+SCR_BITS-1:0] base_full;

  logic [SQ_BITS:0]     dsum;
  logic                 disc_hit, mv_nxt, rv_nxt;
  logic [ADDR_BITS-1:0] ma_nxt, ra_nxt;

  logic                        main_valid_r, mirror_valid_r, walk_done_r;
  logic [ADDR_BITS-1:0]        main_address_r, mirror_address_r;
  logic [PORT_COLOR_BITS-1:0]  pixel_color_r;
  logic                        out_v_r;

  assign out_adv  = !out_v_r || out_ready;
  assign s1_ready = !s1_v_r || out_adv;
  assign job_pop  = job_valid && s1_ready;

  // stage one: the squares and the row base
  assign dx2_full  = job.dx * job.dx;
  assign dy2_full  = job.dy * job.dy;
  assign rsq_full  = job.radius * job.radius;
  assign base_full = job.sy * eff_w;

  always_comb begin
    s1_nxt.active    = job.active;
    s1_nxt.kind      = job.kind;
    s1_nxt.main_on   = job.main_on;
    s1_nxt.mirror_on = job.mirror_on;
    s1_nxt.sx        = job.sx;
    s1_nxt.mx        = job.mx;
    s1_nxt.row_base  = base_full[ADDR_BITS-1:0];
    s1_nxt.dx2       = dx2_full[SQ_BITS-1:0];
    s1_nxt.dy2       = dy2_full[SQ_BITS-1:0];
    s1_nxt.rsq       = rsq_full[SQ_BITS-1:0];
    s1_nxt.color     = job.color;
    s1_nxt.done      = job.done;
  end

  // stage two: radius test and address add
  assign dsum     = {1'b0, s1_r.dx2} + {1'b0, s1_r.dy2};
  assign disc_hit = dsum <= {1'b0, s1_r.rsq};
  assign mv_nxt = s1_r.active && s1_r.main_on && ((s1_r.kind == SHAPE_RECT) || disc_hit);
  assign rv_nxt = mv_nxt && (s1_r.kind == SHAPE_CIRCLE) && s1_r.mirror_on;
  assign ma_nxt = mv_nxt ? s1_r.row_base + {{(ADDR_BITS-PIX_BITS){1'b0}}, s1_r.sx} : '0;
  assign ra_nxt = rv_nxt ? s1_r.row_base + {{(ADDR_BITS-PIX_BITS){1'b0}}, s1_r.mx} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= job_valid;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      s1_r <= s1_nxt;
    end
    if (out_adv && s1_v_r) begin
      main_valid_r      <= mv_nxt;
      main_address_r    <= ma_nxt;
      mirror_valid_r    <= rv_nxt;
      mirror_address_r  <= ra_nxt;
      pixel_color_r     <= PORT_COLOR_BITS'(s1_r.color);
      walk_done_r       <= s1_r.done;
    end
  end

  assign out_valid          = out_v_r;
  assign out_main_valid     = main_valid_r;
  assign out_main_address   = main_address_r;
  assign out_mirror_valid   = mirror_valid_r;
  assign out_mirror_address = mirror_address_r;
  assign out_pixel_color    = pixel_color_r;
  assign out_walk_done      = walk_done_r;

endmodule

`default_nettype wire

// ===== hdl/clipped_rect_circle_fill_top.sv =====
`default_nettype none

// Rectangle and filled-circle fill engine with screen clipping. A load item
// (operation 0) latches a shape and its colour and gives no result; each step
// item (operation 1) gives exactly one result: up to two pixel writes as linear
// addresses y*width+x, the colour, and walk_done on the last iteration or when
// idle. One item is taken per clock while the queue is not full: the front part
// tracks the walk and classifies each iteration combinationally, a four-entry
// queue decouples it from the back part, which spends two register stages
// (squares and row base, then radius test and address add) before the result
// is presented. in_ready drops only when the queue is full because results
// are not being taken. Write
// screen_width/screen_height only while idle; values above 1024 are treated as 1024.
module clipped_rect_circle_fill_top import ccf_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_operation,
  input  wire logic                        in_shape_kind,
  input  wire logic [POS_BITS-1:0]         in_pos_x,
  input  wire logic [POS_BITS-1:0]         in_pos_y,
  input  wire logic [SCR_BITS-1:0]         in_extent_w,
  input  wire logic [SCR_BITS-1:0]         in_extent_h,
  input  wire logic [RAD_BITS-1:0]         in_circle_radius,
  input  wire logic [PORT_COLOR_BITS-1:0]  in_fill_color,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_main_valid,
  output logic [ADDR_BITS-1:0]             out_main_address,
  output logic                             out_mirror_valid,
  output logic [ADDR_BITS-1:0]             out_mirror_address,
  output logic [PORT_COLOR_BITS-1:0]       out_pixel_color,
  output logic                             out_walk_done,
  input  wire logic                        cfg_write_en,
  input  wire logic                        cfg_index,
  input  wire logic [SCR_BITS-1:0]         cfg_data
);

  logic [SCR_BITS-1:0] screen_width_r, screen_height_r;
  logic [SCR_BITS-1:0] eff_w, eff_h;
  logic                q_full, q_valid, q_pop, push, accept;
  job_t                push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RESET_WIDTH;
      screen_height_r <= RESET_HEIGHT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w    = sat_dim(screen_width_r, MAX_SCREEN_WIDTH);
  assign eff_h    = sat_dim(screen_height_r, MAX_SCREEN_HEIGHT);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  ccf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .operation     (in_operation),
    .shape_kind    (in_shape_kind),
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .extent_w      (in_extent_w),
    .extent_h      (in_extent_h),
    .circle_radius (in_circle_radius),
    .fill_color    (in_fill_color[COLOR_BITS-1:0]),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .push          (push),
    .job           (push_job)
  );

  ccf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_job)
  );

  ccf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (q_valid),
    .job                (pop_job),
    .job_pop            (q_pop),
    .eff_w              (eff_w),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_main_valid     (out_main_valid),
    .out_main_address   (out_main_address),
    .out_mirror_valid   (out_mirror_valid),
    .out_mirror_address (out_mirror_address),
    .out_pixel_color    (out_pixel_color),
    .out_walk_done      (out_walk_done)
  );

`ifndef NO_ASSERTIONS
  // a mirror pixel is only ever written alongside its main pixel
  a_mirror_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_mirror_valid || out_main_valid))
    else $error("mirror write without main write");

  // skipped pixels report a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_main_valid) |-> (out_main_address == '0))
    else $error("non-zero address on skipped pixel");

  // the queue can only fill up behind a stalled result
  a_full_means_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import ccf_pkg::*;

  localparam logic [PORT_COLOR_BITS-1:0] COLOR_MASK = {COLOR_BITS{1'b1}};

  typedef struct packed {
    logic                       op;
    logic                       kind;
    logic [POS_BITS-1:0]        px;
    logic [POS_BITS-1:0]        py;
    logic [SCR_BITS-1:0]        ew;
    logic [SCR_BITS-1:0]        eh;
    logic [RAD_BITS-1:0]        rad;
    logic [PORT_COLOR_BITS-1:0] color;
  } shape_item_t;

  typedef struct packed {
    logic                       main_v;
    logic [ADDR_BITS-1:0]       main_a;
    logic                       mir_v;
    logic [ADDR_BITS-1:0]       mir_a;
    logic [PORT_COLOR_BITS-1:0] color;
    logic                       done;
  } pixel_write_t;

  // tracks the raster walk and holds the pixel writes still owed by the block
  class fill_walk_tracker;
    logic [SCR_BITS-1:0]        scr_w = RESET_WIDTH;
    logic [SCR_BITS-1:0]        scr_h = RESET_HEIGHT;
    logic                       kind = SHAPE_RECT;
    logic signed [POS_BITS-1:0] org_x = '0;
    logic signed [POS_BITS-1:0] org_y = '0;
    int                         row_lim = 0;
    int                         col_lim = 0;
    int                         rad = 0;
    int                         row_idx = 0;
    int                         col_idx = 0;
    logic [PORT_COLOR_BITS-1:0] color = '0;
    bit                         busy = 1'b0;
    pixel_write_t               pending_writes[$];
    int                         errors = 0;

    function void set_screen(logic idx, logic [SCR_BITS-1:0] v);
      if (idx == REG_SCREEN_WIDTH) scr_w = v;
      else scr_h = v;
    endfunction

    function bit visible(int x, int y, int w, int h);
      return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    function logic [ADDR_BITS-1:0] linear(int x, int y, int w);
      int a;
      a = y * w + x;
      return a[ADDR_BITS-1:0];
    endfunction

    function void take_item(shape_item_t it);
      int w, h, ox, oy, r, sx, sy, mx, dx, dy;
      pixel_write_t want;
      w = (scr_w > MAX_SCREEN_WIDTH) ? MAX_SCREEN_WIDTH : scr_w;
      h = (scr_h > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT : scr_h;
      if (it.op == OP_LOAD) begin
        kind  = it.kind;
        org_x = it.px;
        org_y = it.py;
        rad   = it.rad;
        color = it.color;
        if (kind == SHAPE_CIRCLE) begin
          row_lim = 2 * rad;
          col_lim = rad;
        end else begin
          row_lim = it.eh;
          col_lim = it.ew;
        end
        row_idx = 0;
        col_idx = 0;
        busy = row_lim != 0 && col_lim != 0;
        return;
      end
      want = '0;
      want.color = color & COLOR_MASK;
      if (!busy) begin
        want.done = 1'b1;
      end else begin
        ox = org_x;
        oy = org_y;
        if (kind == SHAPE_RECT) begin
          sx = ox + col_idx;
          sy = oy + row_idx;
          if (visible(sx, sy, w, h)) begin
            want.main_v = 1'b1;
            want.main_a = linear(sx, sy, w);
          end
        end else begin
          r  = rad;
          sy = oy - r + row_idx;
          sx = ox - r + col_idx;
          dx = col_idx - r;
          dy = row_idx - r;
          if (visible(sx, sy, w, h) && dx * dx + dy * dy <= r * r) begin
            mx = ox + r - col_idx;
            want.main_v = 1'b1;
            want.main_a = linear(sx, sy, w);
            if (visible(mx, sy, w, h)) begin
              want.mir_v = 1'b1;
              want.mir_a = linear(mx, sy, w);
            end
          end
        end
        col_idx++;
        if (col_idx >= col_lim) begin
          col_idx = 0;
          row_idx++;
          if (row_idx >= row_lim) begin
            row_idx = 0;
            busy = 1'b0;
            want.done = 1'b1;
          end
        end
      end
      pending_writes.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void match_write(pixel_write_t got);
      pixel_write_t want;
      if (pending_writes.size() == 0) begin
        $error("result transfer with no step item outstanding");
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      compare_field("main_valid", want.main_v, got.main_v);
      compare_field("main_address", want.main_a, got.main_a);
      compare_field("mirror_valid", want.mir_v, got.mir_v);
      compare_field("mirror_address", want.mir_a, got.mir_a);
      compare_field("pixel_color", want.color, got.color);
      compare_field("walk_done", want.done, got.done);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_operation;
  logic                       in_shape_kind;
  logic [POS_BITS-1:0]        in_pos_x;
  logic [POS_BITS-1:0]        in_pos_y;
  logic [SCR_BITS-1:0]        in_extent_w;
  logic [SCR_BITS-1:0]        in_extent_h;
  logic [RAD_BITS-1:0]        in_circle_radius;
  logic [PORT_COLOR_BITS-1:0] in_fill_color;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_main_valid;
  logic [ADDR_BITS-1:0]       out_main_address;
  logic                       out_mirror_valid;
  logic [ADDR_BITS-1:0]       out_mirror_address;
  logic [PORT_COLOR_BITS-1:0] out_pixel_color;
  logic                       out_walk_done;
  logic                       cfg_write_en;
  logic                       cfg_index;
  logic [SCR_BITS-1:0]        cfg_data;

  fill_walk_tracker walker = new();
  int items_sent = 0;
  int in_gap_max = 5;
  int out_gap_max = 5;
  bit hold_req = 1'b0;

  clipped_rect_circle_fill_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_shape_kind      (in_shape_kind),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_extent_w        (in_extent_w),
    .in_extent_h        (in_extent_h),
    .in_circle_radius   (in_circle_radius),
    .in_fill_color      (in_fill_color),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_main_valid     (out_main_valid),
    .out_main_address   (out_main_address),
    .out_mirror_valid   (out_mirror_valid),
    .out_mirror_address (out_mirror_address),
    .out_pixel_color    (out_pixel_color),
    .out_walk_done      (out_walk_done),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic shape_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(shape_item_t)-1:0];
  endfunction

  function automatic shape_item_t step_item();
    shape_item_t it;
    it = random_item();
    it.op = OP_STEP;
    return it;
  endfunction

  function automatic shape_item_t load_item(logic kind, int x, int y, int ew, int eh,
                                            int r, logic [PORT_COLOR_BITS-1:0] c);
    shape_item_t it;
    it.op    = OP_LOAD;
    it.kind  = kind;
    it.px    = x[POS_BITS-1:0];
    it.py    = y[POS_BITS-1:0];
    it.ew    = ew[SCR_BITS-1:0];
    it.eh    = eh[SCR_BITS-1:0];
    it.rad   = r[RAD_BITS-1:0];
    it.color = c;
    return it;
  endfunction

  // mostly near the visible area so that edges get clipped, now and then anywhere
  function automatic int random_coord(int span);
    if (span > 1024) span = 1024;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, span + 16) - 8;
  endfunction

  task automatic push_item(shape_item_t it);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= it.op;
    in_shape_kind    <= it.kind;
    in_pos_x         <= it.px;
    in_pos_y         <= it.py;
    in_extent_w      <= it.ew;
    in_extent_h      <= it.eh;
    in_circle_radius <= it.rad;
    in_fill_color    <= it.color;
    do @(posedge clk); while (!in_ready);
    walker.take_item(it);
    items_sent++;
  endtask

  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (walker.pending_writes.size() != 0) @(posedge clk);
  endtask

  // a load gives no result, so leave time for it to clear the pipeline too
  task automatic settle();
    drain_writes();
    repeat (8) @(posedge clk);
  endtask

  task automatic set_screen_size(int w, int h);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_SCREEN_WIDTH;
    cfg_data     <= w[SCR_BITS-1:0];
    @(posedge clk);
    walker.set_screen(REG_SCREEN_WIDTH, w[SCR_BITS-1:0]);
    cfg_index    <= REG_SCREEN_HEIGHT;
    cfg_data     <= h[SCR_BITS-1:0];
    @(posedge clk);
    walker.set_screen(REG_SCREEN_HEIGHT, h[SCR_BITS-1:0]);
    cfg_write_en <= 1'b0;
  endtask

  task automatic walk_shape(int room);
    shape_item_t it;
    logic kind;
    int x, y, ew, eh, r, iters, steps;
    kind = ($urandom_range(0, 1) == 1) ? SHAPE_CIRCLE : SHAPE_RECT;
    x  = random_coord(int'(walker.scr_w));
    y  = random_coord(int'(walker.scr_h));
    ew = ($urandom_range(0, 19) == 0) ? int'($urandom) : int'($urandom_range(0, 8));
    eh = ($urandom_range(0, 19) == 0) ? int'($urandom) : int'($urandom_range(0, 8));
    r  = ($urandom_range(0, 19) == 0) ? int'($urandom) : int'($urandom_range(0, 5));
    it = load_item(kind, x, y, ew, eh, r, $urandom);
    iters = (it.kind == SHAPE_CIRCLE) ? 2 * int'(it.rad) * int'(it.rad)
                                      : int'(it.ew) * int'(it.eh);
    push_item(it);
    // sometimes cut the walk short so the next load lands mid-shape
    if ($urandom_range(0, 6) == 0) steps = $urandom_range(0, iters);
    else steps = iters + $urandom_range(0, 2);
    if (steps > 160) steps = $urandom_range(1, 160);
    // keep the stream close to its item count
    if (steps > room - 1) steps = room - 1;
    repeat (steps) push_item(step_item());
  endtask

  task automatic random_stream(int n);
    int stop;
    shape_item_t it;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 82) begin
        walk_shape(stop - items_sent);
      end else begin
        it = random_item();
        push_item(it);
      end
    end
  endtask

  task automatic run_phase(int w, int h, int n);
    settle();
    set_screen_size(w, h);
    random_stream(n);
  endtask

  task automatic directed_items();
    push_item(step_item());
    push_item(load_item(SHAPE_RECT, -2048, -2048, 2047, 2047, 1023, 32'hFFFF_FFFF));
    push_item(step_item());
    push_item(step_item());
    // zero height, then idle steps
    push_item(load_item(SHAPE_RECT, 2047, 2047, 5, 0, 0, 32'h0));
    push_item(step_item());
    push_item(step_item());
    push_item(load_item(SHAPE_CIRCLE, 0, 0, 0, 0, 1023, 32'h0));
    push_item(step_item());
    push_item(step_item());
    push_item(load_item(SHAPE_CIRCLE, 20, 20, 2047, 2047, 0, 32'h1234_5678));
    push_item(step_item());
    // x origin distinct from y, right edge clips the last column
    push_item(load_item(SHAPE_RECT, 638, 478, 3, 1, 0, 32'hA5A5_5A5A));
    repeat (3) push_item(step_item());
    push_item(load_item(SHAPE_CIRCLE, 5, 5, 0, 0, 1, 32'h0F0F_F0F0));
    repeat (3) push_item(step_item());
    // new load abandons the walk in progress
    push_item(load_item(SHAPE_RECT, 0, 0, 2, 2, 0, 32'h0000_0001));
    push_item(step_item());
    push_item(load_item(SHAPE_RECT, 10, 10, 1, 1, 0, 32'h8000_0000));
    push_item(step_item());
    push_item(step_item());
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_operation     <= OP_LOAD;
    in_shape_kind    <= SHAPE_RECT;
    in_pos_x         <= '0;
    in_pos_y         <= '0;
    in_extent_w      <= '0;
    in_extent_h      <= '0;
    in_circle_radius <= '0;
    in_fill_color    <= '0;
    cfg_write_en     <= 1'b0;
    cfg_index        <= REG_SCREEN_WIDTH;
    cfg_data         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    run_phase(640, 480, 95);
    // long receiver hold-off while the stream keeps coming
    settle();
    set_screen_size(1024, 1024);
    hold_req = 1'b1;
    random_stream(95);
    run_phase(2047, 1500, 50);
    drain_writes();
    random_stream(45);
    in_gap_max  = 0;
    out_gap_max = 0;
    run_phase(20, 13, 95);
    in_gap_max  = 5;
    out_gap_max = 5;
    run_phase(1, 1, 60);
    run_phase(0, 300, 60);
    run_phase(300, 0, 60);
    run_phase(1025, 7, 80);
    run_phase(37, 1024, 95);

    drain_writes();
    repeat (20) @(posedge clk);
    if (walker.errors == 0 && walker.pending_writes.size() == 0) begin
      $display("clipped_rect_circle_fill_top verification clean");
    end else begin
      $display("clipped_rect_circle_fill_top verification failed");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    pixel_write_t got;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.main_v = out_main_valid;
      got.main_a = out_main_address;
      got.mir_v  = out_mirror_valid;
      got.mir_a  = out_mirror_address;
      got.color  = out_pixel_color;
      got.done   = out_walk_done;
      walker.match_write(got);
    end
  end

  initial begin
    #5_000_000;
    $display("clipped_rect_circle_fill_top verification failed");
    $finish;
  end

endmodule
